// ===== hdl/wildcard_glob_matcher_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the wildcard glob matcher
// Concurrent checks clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_GLOB_MATCHER_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_MACROS_SVH

// Antecedent true implies consequent in the same cycle.
`define WGM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wgm check failed");

// Antecedent true implies consequent in the next cycle.
`define WGM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wgm check failed");

// Expression holds at every edge.
`define WGM_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("wgm check failed");

`endif

// ===== hdl/wgm_pkg.sv =====
// ---------------------------------------------------------------------------
// wgm_pkg
// Shared constants and types for the wildcard glob matcher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wgm_pkg;

    localparam int PATTERN_LEN_DEF = 64;

    // request action codes
    localparam logic [1:0] ACT_PATTERN = 2'd0;
    localparam logic [1:0] ACT_TEXT    = 2'd1;
    localparam logic [1:0] ACT_END     = 2'd2;

    localparam logic [7:0] CH_QMARK = 8'h3F;  // '?'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_UPA   = 8'h41;  // 'A'
    localparam logic [7:0] CH_UPZ   = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_LOWA  = 8'h61;  // 'a'

    // broadcast from the top level to every cell
    typedef struct packed {
        logic       load;   // store char in the first free cell
        logic       step;   // advance on a text char
        logic       clear;  // back to the reset state
        logic [7:0] ch;     // case-folded char
    } ctrl_t;

    // passed from cell i to cell i+1
    typedef struct packed {
        logic valid;  // cell i holds a pattern char
        logic close;  // star closure into position i+1
        logic match;  // char match moves position i to i+1
        logic lead;   // leading-star closure while loading
    } link_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UPA && c <= CH_UPZ)
        begin
            r = c - CH_UPA + CH_LOWA;
        end
        return r;
    endfunction

endpackage

// ===== hdl/wgm_req_if.sv =====
// ---------------------------------------------------------------------------
// wgm_req_if
// Request channel: action code and char byte with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wgm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_byte;

    modport source (output valid, output action, output char_byte, input ready);
    modport sink   (input valid, input action, input char_byte, output ready);
endinterface

// ===== hdl/wgm_res_if.sv =====
// ---------------------------------------------------------------------------
// wgm_res_if
// Result channel: match flag and overflow flag with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wgm_res_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== hdl/wgm_cell.sv =====
// ---------------------------------------------------------------------------
// wgm_cell
// One pattern position: stored char, fill flag and active bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wgm_cell #(
    parameter bit IS_ORIGIN = 1'b0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  wgm_pkg::ctrl_t ctrl,
    input  wgm_pkg::link_t link_in,
    output wgm_pkg::link_t link_out,
    output logic           hit
);

    logic       valid_reg, valid_next;
    logic       act_reg, act_next;
    logic [7:0] char_reg;
    logic       star_reg;
    logic       qmark_reg;

    logic       wr;
    logic       in_star;
    logic       active_c;

    assign wr      = ctrl.load && !valid_reg && link_in.valid;
    assign in_star = (ctrl.ch == wgm_pkg::CH_STAR);

    // closed active set for this position after a text char
    assign active_c = (act_reg && valid_reg && star_reg) || link_in.match || link_in.close;

    assign link_out.valid = valid_reg;
    assign link_out.close = active_c && valid_reg && star_reg;
    assign link_out.match = act_reg && valid_reg && !star_reg
                            && (qmark_reg || (char_reg == ctrl.ch));
    assign link_out.lead  = act_reg && wr && in_star;

    // active but unfilled: this is the end-of-pattern position
    assign hit = act_reg && !valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        act_next   = act_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
            act_next   = IS_ORIGIN;
        end
        else if (ctrl.step)
        begin
            act_next = active_c;
        end
        else if (ctrl.load)
        begin
            valid_next = valid_reg || wr;
            act_next   = act_reg || link_in.lead;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            act_reg   <= IS_ORIGIN;
        end
        else
        begin
            valid_reg <= valid_next;
            act_reg   <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            char_reg  <= ctrl.ch;
            star_reg  <= in_star;
            qmark_reg <= (ctrl.ch == wgm_pkg::CH_QMARK);
        end
    end

endmodule

// ===== hdl/wildcard_glob_matcher.sv =====
// ---------------------------------------------------------------------------
// wildcard_glob_matcher
// Case-insensitive '*' / '?' glob match of a streamed text.
// ---------------------------------------------------------------------------
// Usage: send pattern chars (action 0), then text chars (action 1), then an
// end request (action 2), which returns one result and clears the block for
// the next pattern. A new request is taken in each cycle as long as the
// result register is empty or being drained; the sustained rate is then
// one request per clock. The end result is registered and appears in the
// cycle after its request. The clock period is set by the star-closure path,
// which ripples through the row of PATTERN_LEN+1 cells like a carry chain.
// Only 'A'..'Z' are folded; a pattern '*' always acts as a wildcard; pattern
// chars after the first text char are dropped; more than PATTERN_LEN
// pattern chars set pattern_overflow and force matched to 0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "wildcard_glob_matcher_macros.svh"

module wildcard_glob_matcher #(
    parameter int PATTERN_LEN = wgm_pkg::PATTERN_LEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    wgm_req_if.sink   req,
    wgm_res_if.source res
);

    // Position i of the NFA lives in cell i. Cells 0..PATTERN_LEN-1 can hold
    // a pattern char; cell PATTERN_LEN is the end position past a full store
    // and is never filled. The active vector is kept closed over stars at
    // all times: during loading a leading star run extends the origin, and
    // each text step closes its own result through the chain.

    wgm_pkg::ctrl_t ctrl;
    wgm_pkg::link_t link [0:PATTERN_LEN];
    wgm_pkg::link_t tail_link;
    logic [PATTERN_LEN:0] hit_vec;

    logic text_started_reg, text_started_next;
    logic ovf_reg, ovf_next;
    logic res_valid_reg, res_valid_next;
    logic res_matched_reg, res_matched_next;
    logic res_ovf_reg, res_ovf_next;

    logic accept;
    logic full;
    logic is_pattern;

    // a new request fits whenever the result slot is free or draining
    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    // the last storage cell filled means the pattern store is full
    assign full       = link[PATTERN_LEN].valid;
    assign is_pattern = accept && (req.action == wgm_pkg::ACT_PATTERN) && !text_started_reg;

    always_comb
    begin
        ctrl.load  = 1'b0;
        ctrl.step  = 1'b0;
        ctrl.clear = 1'b0;
        ctrl.ch    = wgm_pkg::fold_case(req.char_byte);
        if (accept)
        begin
            case (req.action)
                wgm_pkg::ACT_PATTERN: ctrl.load  = !text_started_reg && !full;
                wgm_pkg::ACT_TEXT:    ctrl.step  = 1'b1;
                wgm_pkg::ACT_END:     ctrl.clear = 1'b1;
                default:              ctrl.load  = 1'b0;
            endcase
        end
    end

    // origin link: position 0 has nothing before it
    assign link[0] = '{valid: 1'b1, close: 1'b0, match: 1'b0, lead: 1'b0};

    for (genvar i = 0; i <= PATTERN_LEN; i++)
    begin : g_cell
        if (i < PATTERN_LEN)
        begin : g_store
            wgm_cell #(
                .IS_ORIGIN (i == 0)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .link_in  (link[i]),
                .link_out (link[i+1]),
                .hit      (hit_vec[i])
            );
        end
        else
        begin : g_tail
            // end position for a full store; its load enable never fires
            wgm_cell #(
                .IS_ORIGIN (i == 0)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .link_in  (link[i]),
                .link_out (tail_link),
                .hit      (hit_vec[i])
            );
        end
    end

    always_comb
    begin
        text_started_next = text_started_reg;
        ovf_next          = ovf_reg;
        res_valid_next    = res_valid_reg && !res.ready;
        res_matched_next  = res_matched_reg;
        res_ovf_next      = res_ovf_reg;
        if (ctrl.step)
        begin
            text_started_next = 1'b1;
        end
        if (is_pattern && full)
        begin
            ovf_next = 1'b1;
        end
        if (ctrl.clear)
        begin
            // only the end position can be active among unfilled cells
            res_valid_next    = 1'b1;
            res_matched_next  = (|hit_vec) && !ovf_reg;
            res_ovf_next      = ovf_reg;
            text_started_next = 1'b0;
            ovf_next          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_started_reg <= 1'b0;
            ovf_reg          <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            text_started_reg <= text_started_next;
            ovf_reg          <= ovf_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_matched_reg <= res_matched_next;
        res_ovf_reg     <= res_ovf_next;
    end

    assign res.valid            = res_valid_reg;
    assign res.matched          = res_matched_reg;
    assign res.pattern_overflow = res_ovf_reg;

    // ---- checks ----
    // an end request always leaves a result and a clean matcher behind
    `WGM_ASSERT_NEXT(a_end_result, ctrl.clear, res_valid_reg && !text_started_reg && !ovf_reg)
    // overflow always forces a miss
    `WGM_ASSERT_SAME(a_ovf_miss, res_valid_reg && res_ovf_reg, !res_matched_reg)
    // at most one active position past the filled part of the store
    `WGM_ASSERT_ALWAYS(a_one_end, $onehot0(hit_vec))
    // the end position cell never takes a char or feeds anything onward
    `WGM_ASSERT_ALWAYS(a_tail_idle, tail_link == '0)

endmodule
